// ===== sv/ztsg_pkg.sv =====
// ztsg_pkg: shared types, constants and helpers of the z-order tile sample generator
// no dependencies
package ztsg_pkg;

	localparam int TILE_COUNT       = 4096;
	localparam int DIM_COUNT        = 16;
	localparam int MAX_DEPTH        = 16;
	localparam int MAX_SAMPLES_LOG2 = 6;
	localparam int PERM_DEPTH       = 96;
	localparam int SOBOL_DEPTH      = 64;

	localparam int TILE_W  = $clog2(TILE_COUNT);
	localparam int DIM_W   = $clog2(DIM_COUNT);
	localparam int PROD_AW = TILE_W + 2;
	localparam int RANK_AW = DIM_W + TILE_W;
	localparam int PERM_AW = 7;
	localparam int SOBOL_AW = 6;

	typedef enum logic [2:0] {
		FN_GENERATE  = 3'd0,
		FN_PROD_WR   = 3'd1,
		FN_RANK_WR   = 3'd2,
		FN_C2R_WR    = 3'd3,
		FN_R2C_WR    = 3'd4,
		FN_MATRIX_WR = 3'd5
	} func_t;

	localparam logic REG_TILE_DEPTH   = 1'b0;
	localparam logic REG_SAMPLES_LOG2 = 1'b1;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic [3:0]  dimension;
		logic [15:0] table_index;
		logic [31:0] table_word;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  sample_position;
		logic [31:0] sample_x;
		logic [31:0] sample_y;
		logic        last;
	} out_word_t;

	// table write request from the front end
	typedef struct packed {
		logic        en;
		logic [2:0]  func;
		logic [15:0] index;
		logic [31:0] data;
	} tbl_wr_t;

	// index of lowest set bit of a 7-bit nonzero value
	function automatic logic [2:0] low_bit(input logic [6:0] v);
		logic [2:0] n;
		n = 3'd0;
		for (int b = 6; b >= 0; b--) begin
			if (v[b]) n = 3'(b);
		end
		return n;
	endfunction

endpackage

// ===== sv/ztsg_tables.sv =====
// ztsg_tables: production, rank, permutation and sobol column memories
// depends on ztsg_pkg
module ztsg_tables (
	input  logic                              clk,
	input  ztsg_pkg::tbl_wr_t                 wr,
	input  logic [ztsg_pkg::PROD_AW-1:0]      prod_addr,
	output logic [11:0]                       prod_data,
	input  logic [ztsg_pkg::RANK_AW-1:0]      rank_addr,
	output logic [4:0]                        rank_data,
	input  logic [ztsg_pkg::PERM_AW-1:0]      perm_addr,
	output logic [1:0]                        c2r_data,
	output logic [1:0]                        r2c_data,
	input  logic [ztsg_pkg::SOBOL_AW-1:0]     sob_addr_a,
	input  logic [ztsg_pkg::SOBOL_AW-1:0]     sob_addr_b,
	output logic [31:0]                       sob_data_a,
	output logic [31:0]                       sob_data_b
);

	logic [11:0] prod_mem [0:ztsg_pkg::TILE_COUNT*4-1];
	logic [4:0]  rank_mem [0:ztsg_pkg::DIM_COUNT*ztsg_pkg::TILE_COUNT-1];
	logic [1:0]  c2r_mem  [0:ztsg_pkg::PERM_DEPTH-1];
	logic [1:0]  r2c_mem  [0:ztsg_pkg::PERM_DEPTH-1];
	logic [31:0] sob_mem  [0:ztsg_pkg::SOBOL_DEPTH-1];

	logic perm_hit;
	assign perm_hit = (32'(perm_addr) < 32'(ztsg_pkg::PERM_DEPTH));

	always_ff @(posedge clk) begin
		if (wr.en) begin
			case (ztsg_pkg::func_t'(wr.func))
				ztsg_pkg::FN_PROD_WR: begin
					if (32'(wr.index) < 32'(ztsg_pkg::TILE_COUNT*4))
						prod_mem[wr.index[ztsg_pkg::PROD_AW-1:0]] <= wr.data[11:0];
				end
				ztsg_pkg::FN_RANK_WR: begin
					if (32'(wr.index) < 32'(ztsg_pkg::DIM_COUNT*ztsg_pkg::TILE_COUNT))
						rank_mem[wr.index[ztsg_pkg::RANK_AW-1:0]] <= wr.data[4:0];
				end
				ztsg_pkg::FN_C2R_WR: begin
					if (32'(wr.index) < 32'(ztsg_pkg::PERM_DEPTH))
						c2r_mem[wr.index[ztsg_pkg::PERM_AW-1:0]] <= wr.data[1:0];
				end
				ztsg_pkg::FN_R2C_WR: begin
					if (32'(wr.index) < 32'(ztsg_pkg::PERM_DEPTH))
						r2c_mem[wr.index[ztsg_pkg::PERM_AW-1:0]] <= wr.data[1:0];
				end
				ztsg_pkg::FN_MATRIX_WR: begin
					if (32'(wr.index) < 32'(ztsg_pkg::SOBOL_DEPTH))
						sob_mem[wr.index[ztsg_pkg::SOBOL_AW-1:0]] <= wr.data;
				end
				default: ;
			endcase
		end
	end

	// rank choices past the table read as zero
	always_ff @(posedge clk) begin
		prod_data  <= prod_mem[prod_addr];
		rank_data  <= rank_mem[rank_addr];
		c2r_data   <= perm_hit ? c2r_mem[perm_addr] : 2'd0;
		r2c_data   <= perm_hit ? r2c_mem[perm_addr] : 2'd0;
		sob_data_a <= sob_mem[sob_addr_a];
		sob_data_b <= sob_mem[sob_addr_b];
	end

endmodule

// ===== sv/z_order_tile_sample_generator.sv =====
// z_order_tile_sample_generator: top level, apb registers, sequencer and output register
// depends on ztsg_pkg and ztsg_tables
//
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_word  (ztsg_pkg::in_word_t)
// out       output     out_valid / out_ready out_word (ztsg_pkg::out_word_t)
// apb       input      psel / penable        paddr, pwdata, prdata
//
// a table write word is taken in the idle state; a generate word walks the tile
// tree through the single-read-port tables, every level one after another,
// then sums the sobol base and resolves each sample's slot bits two at a time
// (one bit first for an odd count) before it loads the output register
// reset clears the config registers and control state; tables hold garbage until written
// a stalled out channel holds the sequencer in the output wait state
module z_order_tile_sample_generator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  ztsg_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output ztsg_pkg::out_word_t out_word
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_WK_A, ST_WK_B, ST_WK_C, ST_SOB,
		ST_SL_INIT, ST_SL_A, ST_SL_B, ST_SL_C, ST_SL_D, ST_OUTW, ST_UPD
	} state_t;

	state_t state_q;

	// config registers
	logic [4:0] tile_depth_q;
	logic [2:0] samples_log2_q;

	// item registers
	logic [15:0] px_q, py_q;
	logic [ztsg_pkg::DIM_W-1:0]  dim_q;
	logic [4:0]  d_q;           // digits still to walk
	logic [2:0]  k_q;           // clamped samples_log2
	logic [ztsg_pkg::TILE_W-1:0] tile_q, tile_nx_q, stile_q;
	logic [31:0] seq_q, base_q, fx_q, fy_q;
	logic [5:0]  col_q;         // sobol column sweep, 0..32
	logic        acc_q;         // column read last cycle is to be folded in
	logic [5:0]  i_q, code_q, pos_q;
	logic [2:0]  bits_q;        // slot bits still to resolve
	logic        out_valid_q;
	ztsg_pkg::out_word_t out_q;

	// table ports
	ztsg_pkg::tbl_wr_t wr;
	logic [ztsg_pkg::PROD_AW-1:0]  prod_addr;
	logic [ztsg_pkg::RANK_AW-1:0]  rank_addr;
	logic [ztsg_pkg::PERM_AW-1:0]  perm_addr;
	logic [ztsg_pkg::SOBOL_AW-1:0] sob_addr_a, sob_addr_b;
	logic [11:0] prod_data;
	logic [4:0]  rank_data;
	logic [1:0]  c2r_data, r2c_data;
	logic [31:0] sob_data_a, sob_data_b;

	logic        in_acc;
	logic [3:0]  sh;            // current pixel digit
	logic [1:0]  child;
	logic [1:0]  r_pair;
	logic [2:0]  tz;
	logic        last_w;
	logic        out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign pready    = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	assign sh     = 4'(d_q - 5'd1);
	assign child  = {py_q[sh], px_q[sh]};
	assign r_pair = 2'(code_q >> (bits_q - 3'd2));
	assign tz     = ztsg_pkg::low_bit(7'(i_q) + 7'd1);
	assign last_w = (7'(i_q) == (7'd1 << k_q) - 7'd1);

	assign wr = '{en: in_acc && (in_word.func != 3'(ztsg_pkg::FN_GENERATE)),
		func: in_word.func, index: in_word.table_index, data: in_word.table_word};

	// read addresses follow the sequencer state
	always_comb begin
		rank_addr  = {dim_q, (state_q == ST_WK_A) ? tile_q : stile_q};
		prod_addr  = (state_q == ST_WK_A) ? {tile_q, child} : {stile_q, r2c_data};
		perm_addr  = {rank_data, child};
		sob_addr_a = {1'b0, col_q[4:0]};
		sob_addr_b = {1'b1, col_q[4:0]};
		case (state_q)
			ST_SL_B: perm_addr = bits_q[0] ? {rank_data, 2'b00} : {rank_data, r_pair};
			ST_OUTW: begin
				sob_addr_a = {3'b000, tz};
				sob_addr_b = {3'b100, tz};
			end
			default: ;
		endcase
	end

	// apb registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_depth_q   <= '0;
			samples_log2_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == ztsg_pkg::REG_TILE_DEPTH) tile_depth_q <= pwdata[4:0];
			else samples_log2_q <= pwdata[2:0];
		end
	end

	assign prdata = (paddr[2] == ztsg_pkg::REG_TILE_DEPTH) ? {27'd0, tile_depth_q}
		: {29'd0, samples_log2_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			d_q         <= '0;
			i_q         <= '0;
			col_q       <= '0;
			acc_q       <= 1'b0;
		end else begin
			// output register loads when empty or while its word leaves
			if (state_q == ST_OUTW && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_word.func == 3'(ztsg_pkg::FN_GENERATE)) begin
						px_q    <= in_word.pixel_x;
						py_q    <= in_word.pixel_y;
						dim_q   <= in_word.dimension[ztsg_pkg::DIM_W-1:0];
						d_q     <= (tile_depth_q > 5'(ztsg_pkg::MAX_DEPTH))
							? 5'(ztsg_pkg::MAX_DEPTH) : tile_depth_q;
						k_q     <= (samples_log2_q > 3'(ztsg_pkg::MAX_SAMPLES_LOG2))
							? 3'(ztsg_pkg::MAX_SAMPLES_LOG2) : samples_log2_q;
						tile_q  <= '0;
						seq_q   <= 32'd1;
						state_q <= ST_WK_A;
					end
				end
				ST_WK_A: begin
					if (d_q == 5'd0) begin
						base_q  <= seq_q << k_q;
						fx_q    <= '0;
						fy_q    <= '0;
						col_q   <= '0;
						acc_q   <= 1'b0;
						state_q <= ST_SOB;
					end else begin
						state_q <= ST_WK_B;
					end
				end
				ST_WK_B: begin
					tile_nx_q <= prod_data[ztsg_pkg::TILE_W-1:0];
					state_q   <= ST_WK_C;
				end
				ST_WK_C: begin
					seq_q   <= {seq_q[29:0], c2r_data};
					tile_q  <= tile_nx_q;
					d_q     <= d_q - 5'd1;
					state_q <= ST_WK_A;
				end
				ST_SOB: begin
					if (acc_q) begin
						fx_q <= fx_q ^ sob_data_a;
						fy_q <= fy_q ^ sob_data_b;
					end
					acc_q <= !col_q[5] && base_q[col_q[4:0]];
					col_q <= col_q + 6'd1;
					if (col_q[5]) begin
						i_q     <= '0;
						state_q <= ST_SL_INIT;
					end
				end
				ST_SL_INIT: begin
					stile_q <= tile_q;
					pos_q   <= '0;
					bits_q  <= k_q;
					code_q  <= i_q ^ (i_q >> 1);
					state_q <= ST_SL_A;
				end
				ST_SL_A: state_q <= (bits_q == 3'd0) ? ST_OUTW : ST_SL_B;
				ST_SL_B: state_q <= ST_SL_C;
				ST_SL_C: begin
					if (bits_q[0]) begin
						// odd top bit: binary level, tile stays
						pos_q   <= pos_q | (6'(code_q[bits_q - 3'd1] ^ r2c_data[0])
							<< (bits_q - 3'd1));
						bits_q  <= bits_q - 3'd1;
						state_q <= ST_SL_A;
					end else begin
						pos_q   <= pos_q | (6'(r2c_data) << (bits_q - 3'd2));
						bits_q  <= bits_q - 3'd2;
						state_q <= ST_SL_D;
					end
				end
				ST_SL_D: begin
					stile_q <= prod_data[ztsg_pkg::TILE_W-1:0];
					state_q <= ST_SL_A;
				end
				ST_OUTW: begin
					if (out_free) begin
						out_q       <= '{sample_position: pos_q, sample_x: fx_q,
							sample_y: fy_q, last: last_w};
						state_q     <= ST_UPD;
					end
				end
				ST_UPD: begin
					fx_q <= fx_q ^ sob_data_a;
					fy_q <= fy_q ^ sob_data_b;
					if (last_w) begin
						state_q <= ST_IDLE;
					end else begin
						i_q     <= i_q + 6'd1;
						state_q <= ST_SL_INIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ztsg_tables u_tables (
		.clk        (clk),
		.wr         (wr),
		.prod_addr  (prod_addr),
		.prod_data  (prod_data),
		.rank_addr  (rank_addr),
		.rank_data  (rank_data),
		.perm_addr  (perm_addr),
		.c2r_data   (c2r_data),
		.r2c_data   (r2c_data),
		.sob_addr_a (sob_addr_a),
		.sob_addr_b (sob_addr_b),
		.sob_data_a (sob_data_a),
		.sob_data_b (sob_data_b)
	);

`ifndef SYNTHESIS
	a_gen_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_word.func == 3'(ztsg_pkg::FN_GENERATE)) |=> !in_ready)
		else $error("generate word did not start the sequencer");
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		d_q <= 5'(ztsg_pkg::MAX_DEPTH))
		else $error("walk depth beyond limit");
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && out_valid_q) |-> out_q.last)
		else $error("idle with a non-final sample pending");
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUTW && out_free) |=> (out_valid_q && state_q == ST_UPD))
		else $error("sample not loaded into output register");
`endif

endmodule

// ===== tb/tb_z_order_tile_sample_generator.sv =====
// tb_z_order_tile_sample_generator: self-checking bench for the z-order tile sample generator
// depends on ztsg_pkg and z_order_tile_sample_generator
module tb_z_order_tile_sample_generator;

	localparam logic [2:0] ADDR_TILE_DEPTH   = {ztsg_pkg::REG_TILE_DEPTH, 2'b00};
	localparam logic [2:0] ADDR_SAMPLES_LOG2 = {ztsg_pkg::REG_SAMPLES_LOG2, 2'b00};
	localparam int         PERM_CHOICES      = ztsg_pkg::PERM_DEPTH / 4;
	localparam int         USED_CHOICES      = 4;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_ready;
	ztsg_pkg::in_word_t  in_word;
	logic        out_valid, out_ready;
	ztsg_pkg::out_word_t out_word;

	z_order_tile_sample_generator DUT (.*);

	// shadow tables, written only through the same words the block sees
	logic [11:0] sh_prod [0:ztsg_pkg::TILE_COUNT*4-1];
	logic [4:0]  sh_rank [0:ztsg_pkg::DIM_COUNT*ztsg_pkg::TILE_COUNT-1];
	logic [1:0]  sh_c2r  [0:ztsg_pkg::PERM_DEPTH-1];
	logic [1:0]  sh_r2c  [0:ztsg_pkg::PERM_DEPTH-1];
	logic [31:0] sh_cols [0:ztsg_pkg::SOBOL_DEPTH-1];
	logic [4:0]  cur_depth;
	logic [2:0]  cur_log2;

	ztsg_pkg::out_word_t sample_queue [$];
	int          errors;
	int          cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// generous watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [1:0] perm_at(input bit to_child, input logic [4:0] ch,
			input logic [1:0] slot);
		if (ch >= PERM_CHOICES) return 2'd0;
		return to_child ? sh_r2c[{ch, slot}] : sh_c2r[{ch, slot}];
	endfunction

	function automatic logic [31:0] sobol_of(input logic [31:0] idx, input int first);
		logic [31:0] v;
		v = 0;
		for (int c = 0; c < 32; c++) if (idx[c]) v ^= sh_cols[first+c];
		return v;
	endfunction

	function automatic logic [5:0] slot_pos(input logic [5:0] code, input logic [11:0] t0,
			input int k, input logic [3:0] dim);
		logic [5:0]  pos;
		logic [11:0] t;
		logic [1:0]  c;
		logic [1:0]  r0;
		int          b;
		pos = 0; t = t0; b = k;
		if (b & 1) begin
			b--;
			r0 = perm_at(1'b1, sh_rank[{dim, t}], 2'd0);
			pos[b] = code[b] ^ r0[0];
		end
		while (b > 0) begin
			b -= 2;
			c = perm_at(1'b1, sh_rank[{dim, t}], code[b +: 2]);
			pos |= 6'(c) << b;
			t = sh_prod[{t, c}];
		end
		return pos;
	endfunction

	// apply one input word to the shadow state and queue its samples
	task automatic predict_word(input ztsg_pkg::in_word_t w);
		int          depth, k, tz;
		logic [11:0] t;
		logic [31:0] sq, fx, fy;
		logic [1:0]  ch;
		logic [6:0]  i1;
		ztsg_pkg::out_word_t o;
		case (w.func)
			ztsg_pkg::FN_PROD_WR:
				if (32'(w.table_index) < ztsg_pkg::TILE_COUNT*4)
					sh_prod[w.table_index[13:0]] = w.table_word[11:0];
			ztsg_pkg::FN_RANK_WR:
				sh_rank[w.table_index] = w.table_word[4:0];
			ztsg_pkg::FN_C2R_WR:
				if (32'(w.table_index) < ztsg_pkg::PERM_DEPTH)
					sh_c2r[w.table_index[6:0]] = w.table_word[1:0];
			ztsg_pkg::FN_R2C_WR:
				if (32'(w.table_index) < ztsg_pkg::PERM_DEPTH)
					sh_r2c[w.table_index[6:0]] = w.table_word[1:0];
			ztsg_pkg::FN_MATRIX_WR:
				if (32'(w.table_index) < ztsg_pkg::SOBOL_DEPTH)
					sh_cols[w.table_index[5:0]] = w.table_word;
			ztsg_pkg::FN_GENERATE: begin
				depth = cur_depth > ztsg_pkg::MAX_DEPTH ? ztsg_pkg::MAX_DEPTH : cur_depth;
				k = cur_log2 > ztsg_pkg::MAX_SAMPLES_LOG2 ? ztsg_pkg::MAX_SAMPLES_LOG2
					: cur_log2;
				t = 0; sq = 1;
				for (int d = depth; d > 0; d--) begin
					ch = {w.pixel_y[d-1], w.pixel_x[d-1]};
					sq = (sq << 2) | 32'(perm_at(1'b0, sh_rank[{w.dimension, t}], ch));
					t = sh_prod[{t, ch}];
				end
				fx = sobol_of(sq << k, 0);
				fy = sobol_of(sq << k, 32);
				for (int i = 0; i < (1 << k); i++) begin
					o.sample_position = slot_pos(6'(i ^ (i >> 1)), t, k, w.dimension);
					o.sample_x = fx;
					o.sample_y = fy;
					o.last = (i + 1 == (1 << k));
					sample_queue.push_back(o);
					i1 = 7'(i + 1);
					tz = 0;
					while (!i1[tz]) tz++;
					fx ^= sh_cols[tz];
					fy ^= sh_cols[32+tz];
				end
			end
			default: ;
		endcase
	endtask

	// output side: random stall per word, compare against oldest expectation
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) gap = 0;
			out_ready = 0;
			repeat (gap) @(negedge clk);
			out_ready = 1;
			do @(posedge clk); while (!out_valid);
			if (sample_queue.size() == 0) begin
				$display("%0t unexpected sample expected none actual %p", $time, out_word);
				errors++;
			end else begin
				ztsg_pkg::out_word_t e;
				e = sample_queue.pop_front();
				if (e !== out_word) begin
					$display("%0t sample mismatch expected %p actual %p", $time, e, out_word);
					errors++;
				end
			end
		end
	end

	task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1; paddr = a; pwdata = d;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		if (a == ADDR_TILE_DEPTH) cur_depth = d[4:0]; else cur_log2 = d[2:0];
	endtask

	// send one word, with a random lead gap; valid held until accepted
	task automatic send_word(input ztsg_pkg::in_word_t w);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) @(negedge clk);
		in_word = w;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		predict_word(w);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic drain;
		while (sample_queue.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	function automatic ztsg_pkg::in_word_t table_wr(input ztsg_pkg::func_t f, input int idx,
			input logic [31:0] d);
		ztsg_pkg::in_word_t w;
		w = '{func: f, pixel_x: 16'($urandom), pixel_y: 16'($urandom),
			dimension: 4'($urandom), table_index: 16'(idx), table_word: d};
		return w;
	endfunction

	function automatic ztsg_pkg::in_word_t gen_word(input logic [15:0] x,
			input logic [15:0] y, input logic [3:0] dim);
		ztsg_pkg::in_word_t w;
		w = '{func: ztsg_pkg::FN_GENERATE, pixel_x: x, pixel_y: y, dimension: dim,
			table_index: 16'($urandom), table_word: $urandom};
		return w;
	endfunction

	// load the perm entries of the rank choices in use and both matrices
	task automatic load_tables(input bit random_content);
		for (int j = 0; j < USED_CHOICES*4; j++) begin
			send_word(table_wr(ztsg_pkg::FN_C2R_WR, j, random_content ? $urandom : 32'(j)));
			send_word(table_wr(ztsg_pkg::FN_R2C_WR, j,
				random_content ? $urandom : 32'(3 - j % 4)));
		end
		for (int j = 0; j < ztsg_pkg::SOBOL_DEPTH; j++)
			send_word(table_wr(ztsg_pkg::FN_MATRIX_WR, j,
				random_content ? $urandom : 32'h8000_0000 >> (j % 32)));
	endtask

	// directed table: generate rows after a small closed grammar
	typedef struct {
		logic [4:0]  depth;
		logic [2:0]  lg;
		logic [15:0] x, y;
		logic [3:0]  dim;
	} gen_row_t;

	gen_row_t gen_rows [0:6] = '{
		'{5'd0, 3'd0, 16'h0000, 16'h0000, 4'd0},
		'{5'd1, 3'd1, 16'h0001, 16'h0000, 4'd15},
		'{5'd2, 3'd2, 16'h0003, 16'h0002, 4'd1},
		'{5'd16, 3'd6, 16'hffff, 16'hffff, 4'd3},
		'{5'd31, 3'd7, 16'h5555, 16'haaaa, 4'd7},
		'{5'd16, 3'd5, 16'h0000, 16'hffff, 4'd0},
		'{5'd3, 3'd3, 16'h1234, 16'h8765, 4'd2}
	};

	int          n_tiles;

	initial begin
		ztsg_pkg::in_word_t  w;
		ztsg_pkg::out_word_t e;
		errors = 0; cycles = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; in_word = '0;
		cur_depth = 0; cur_log2 = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// register reset values read back
		paddr = ADDR_TILE_DEPTH;
		@(posedge clk);
		if (prdata !== 32'd0) begin
			$display("%0t tile_depth expected %0d actual %0d", $time, 0, prdata);
			errors++;
		end
		@(negedge clk);
		paddr = ADDR_SAMPLES_LOG2;
		@(posedge clk);
		if (prdata !== 32'd0) begin
			$display("%0t samples_log2 expected %0d actual %0d", $time, 0, prdata);
			errors++;
		end
		@(negedge clk);

		// small grammar over tiles 0..3; word bits above the 12-bit entry are dropped
		n_tiles = 4;
		for (int j = 0; j < n_tiles*4; j++)
			send_word(table_wr(ztsg_pkg::FN_PROD_WR, j,
				(j % 2) ? 32'hffff_f000 | 32'(j % 4) : 32'((j * 3) % 4)));
		// one tile of one dimension takes a rank choice past the table
		for (int d = 0; d < ztsg_pkg::DIM_COUNT; d++)
			for (int t = 0; t < n_tiles; t++)
				send_word(table_wr(ztsg_pkg::FN_RANK_WR, d*ztsg_pkg::TILE_COUNT + t,
					(t == 3 && d == 7) ? 32'd31 : 32'((d + t) % USED_CHOICES)));
		load_tables(0);
		// ignored words: out-of-range address and unused func codes
		send_word(table_wr(ztsg_pkg::FN_C2R_WR, 16'hffff, 32'hffff_ffff));
		w = table_wr(ztsg_pkg::FN_MATRIX_WR, 64, 0); w.func = 3'd6; send_word(w);
		w.func = 3'd7; send_word(w);
		drain();

		// first generate at reset settings: one sample at base 1, so both
		// coordinates are column 0 of their matrix
		send_word(gen_word(16'hffff, 16'hffff, 4'd0));
		e = '{sample_position: 6'd0, sample_x: 32'h8000_0000, sample_y: 32'h8000_0000,
			last: 1'b1};
		if (sample_queue.size() != 1 || sample_queue[0] !== e) begin
			$display("%0t reset generate expected %p actual %p", $time, e, sample_queue[0]);
			errors++;
		end
		drain();
		foreach (gen_rows[r]) begin
			apb_write(ADDR_TILE_DEPTH, 32'(gen_rows[r].depth));
			apb_write(ADDR_SAMPLES_LOG2, 32'(gen_rows[r].lg));
			send_word(gen_word(gen_rows[r].x, gen_rows[r].y, gen_rows[r].dim));
			drain();
		end

		// random phases; table content stays inside the loaded grammar
		for (int ph = 0; ph < 6; ph++) begin
			apb_write(ADDR_TILE_DEPTH, 32'($urandom_range(0, 31)));
			apb_write(ADDR_SAMPLES_LOG2, (ph == 0) ? 32'd6 : 32'($urandom_range(0, 7)));
			for (int n = 0; n < 14; n++) begin
				case ($urandom_range(0, 9))
					0: send_word(table_wr(ztsg_pkg::FN_MATRIX_WR, $urandom_range(0, 70),
						$urandom));
					1: send_word(table_wr(ztsg_pkg::func_t'($urandom_range(3, 4)),
						$urandom_range(0, USED_CHOICES*4 + 3), $urandom));
					2: send_word(table_wr(ztsg_pkg::FN_PROD_WR, $urandom_range(0, 15),
						$urandom & 32'hffff_f003));
					3: send_word(table_wr(ztsg_pkg::FN_RANK_WR,
						$urandom_range(0, 15)*ztsg_pkg::TILE_COUNT + $urandom_range(0, 3),
						($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, USED_CHOICES-1))
						: 32'($urandom_range(24, 31))));
					4: begin
						w = table_wr(ztsg_pkg::FN_MATRIX_WR, $urandom, $urandom);
						w.func = 3'($urandom_range(6, 7));
						send_word(w);
					end
					default: send_word(gen_word(16'($urandom), 16'($urandom), 4'($urandom)));
				endcase
			end
			drain();
		end

		if (errors == 0 && sample_queue.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/ztsg_pkg.sv
sv/ztsg_tables.sv
sv/z_order_tile_sample_generator.sv
tb/tb_z_order_tile_sample_generator.sv
